[rtl/dtc_pkg.sv]
// ----------------------------------------------------------------------------
// Detector event trigger classifier: shared types and constants
// Register indexes, status codes, and the words that pass between the front
// end, the queue and the back end.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int ENERGY_WIDTH = 16;
   localparam int COUNT_WIDTH  = 6;
   localparam int ID_WIDTH     = 7;
   localparam int POS_WIDTH    = 6;
   localparam int STATUS_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = 2;
   localparam int QUEUE_LEVEL_WIDTH = 3;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_HIT_THRESHOLD      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAST_TRIGGER_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEAVY_HIT_THRESHOLD     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HEAVY_TRIGGER_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPPER_LIMIT             = 3'd4;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_ACCEPTED   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_TRIGGER = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_VETOED     = 2'd2;

   typedef struct packed {
      logic [ENERGY_WIDTH-1:0] fast_hit_threshold;
      logic [ENERGY_WIDTH-1:0] fast_trigger_threshold;
      logic [ENERGY_WIDTH-1:0] heavy_hit_threshold;
      logic [ENERGY_WIDTH-1:0] heavy_trigger_threshold;
      logic [ENERGY_WIDTH-1:0] upper_limit;
   } dtc_cfg_type;

   // One classified channel position.
   typedef struct packed {
      logic                    skip;
      logic                    veto;
      logic                    arm;
      logic                    fast_hit;
      logic                    heavy_hit;
      logic [ENERGY_WIDTH-1:0] fast_energy;
      logic [ENERGY_WIDTH-1:0] heavy_energy;
      logic [POS_WIDTH-1:0]    pos;
      logic                    last;
   } dtc_entry_type;

   typedef struct packed {
      logic                         full;
      logic                         empty;
      logic [QUEUE_LEVEL_WIDTH-1:0] level;
   } dtc_queue_status_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  fast_hits;
      logic [COUNT_WIDTH-1:0]  heavy_hits;
      logic [ID_WIDTH-1:0]     low_hit_id;
      logic [ID_WIDTH-1:0]     high_hit_id;
      logic [ID_WIDTH-1:0]     photo_id;
      logic [ID_WIDTH-1:0]     compton_id;
   } dtc_result_type;

endpackage

[rtl/dtc_front.sv]
// ----------------------------------------------------------------------------
// Detector event trigger classifier: front end
// Accepts channel words, tracks the channel position, and classifies each
// word into veto, arm and hit flags before it enters the queue.
// ----------------------------------------------------------------------------
module dtc_front #(
   parameter int POSITIONS   = 60,
   parameter int ENERGY_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dtc_pkg::dtc_cfg_type                cfg,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dtc_pkg::ENERGY_WIDTH-1:0]    req_fast_energy,
   input  logic [dtc_pkg::ENERGY_WIDTH-1:0]    req_heavy_energy,
   input  logic                                req_last_channel,
   input  logic                                queue_full,
   output logic                                push,
   output dtc_pkg::dtc_entry_type              entry
);

   localparam int EFF_BITS = (ENERGY_BITS < dtc_pkg::ENERGY_WIDTH) ?
                             ENERGY_BITS : dtc_pkg::ENERGY_WIDTH;
   localparam logic [dtc_pkg::ENERGY_WIDTH-1:0] ENERGY_MASK =
      dtc_pkg::ENERGY_WIDTH'((33'd1 << EFF_BITS) - 33'd1);
   localparam logic [dtc_pkg::POS_WIDTH:0] POS_LIMIT = (dtc_pkg::POS_WIDTH+1)'(POSITIONS);

   logic [dtc_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic                          overrun_ff, overrun_in;
   logic [dtc_pkg::ENERGY_WIDTH-1:0] fe, he;
   logic [dtc_pkg::POS_WIDTH:0]   pos_next;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign fe = req_fast_energy & ENERGY_MASK;
   assign he = req_heavy_energy & ENERGY_MASK;
   assign pos_next = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      entry.skip         = overrun_ff;
      entry.veto         = (fe > cfg.upper_limit) || (he > cfg.upper_limit);
      entry.arm          = (fe > cfg.fast_trigger_threshold) ||
                           (he > cfg.heavy_trigger_threshold);
      // A zero energy is never a hit, even with a zero hit threshold.
      entry.fast_hit     = (fe != '0) && (fe >= cfg.fast_hit_threshold);
      entry.heavy_hit    = (he != '0) && (he >= cfg.heavy_hit_threshold);
      entry.fast_energy  = fe;
      entry.heavy_energy = he;
      entry.pos          = pos_ff;
      entry.last         = req_last_channel;
   end

   always_comb begin
      pos_in     = pos_ff;
      overrun_in = overrun_ff;
      if (push) begin
         if (req_last_channel) begin
            pos_in     = '0;
            overrun_in = 1'b0;
         end else if (!overrun_ff) begin
            if (pos_next >= POS_LIMIT) begin
               overrun_in = 1'b1;
            end else begin
               pos_in = pos_next[dtc_pkg::POS_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         overrun_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         overrun_ff <= overrun_in;
      end
   end

endmodule

[rtl/dtc_queue.sv]
// ----------------------------------------------------------------------------
// Detector event trigger classifier: decoupling queue
// A short first-in first-out buffer of classified words between the front
// end and the back end.
// ----------------------------------------------------------------------------
module dtc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  dtc_pkg::dtc_entry_type        push_entry,
   input  logic                          pop,
   output dtc_pkg::dtc_entry_type        head,
   output dtc_pkg::dtc_queue_status_type status
);

   dtc_pkg::dtc_entry_type mem [dtc_pkg::QUEUE_DEPTH];
   logic [dtc_pkg::QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dtc_pkg::QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dtc_pkg::QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                                  do_push, do_pop;

   assign status.level = level_ff;
   assign status.empty = (level_ff == '0);
   assign status.full  = (level_ff == dtc_pkg::QUEUE_LEVEL_WIDTH'(dtc_pkg::QUEUE_DEPTH));
   assign head         = mem[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

[rtl/dtc_back.sv]
// ----------------------------------------------------------------------------
// Detector event trigger classifier: back end
// Folds classified words into the event state and, on the last channel,
// builds the event result into the output register.
// ----------------------------------------------------------------------------
module dtc_back #(
   parameter int HEAVY_ID_OFFSET = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dtc_pkg::dtc_entry_type head,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dtc_pkg::dtc_result_type rsp
);

   localparam int EW = dtc_pkg::ENERGY_WIDTH;
   localparam int CW = dtc_pkg::COUNT_WIDTH;
   localparam int IW = dtc_pkg::ID_WIDTH;
   localparam logic [IW-1:0] ID_OFFSET = IW'(HEAVY_ID_OFFSET);

   logic          vetoed_ff, vetoed_in;
   logic          armed_ff, armed_in;
   logic [CW-1:0] fast_count_ff, fast_count_in;
   logic [CW-1:0] heavy_count_ff, heavy_count_in;
   logic [IW-1:0] first_id_ff, first_id_in, second_id_ff, second_id_in;
   logic [EW-1:0] first_energy_ff, first_energy_in, second_energy_ff, second_energy_in;
   logic [EW-1:0] fast_peak_energy_ff, fast_peak_energy_in;
   logic [EW-1:0] heavy_peak_energy_ff, heavy_peak_energy_in;
   logic [dtc_pkg::POS_WIDTH-1:0] fast_peak_pos_ff, fast_peak_pos_in;
   logic [dtc_pkg::POS_WIDTH-1:0] heavy_peak_pos_ff, heavy_peak_pos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dtc_pkg::dtc_result_type rsp_ff, rsp_in;

   // Updated event state before the end-of-event clear.
   logic          u_vetoed, u_armed;
   logic [CW-1:0] u_fast_count, u_heavy_count;
   logic [IW-1:0] u_first_id, u_second_id;
   logic [EW-1:0] u_first_energy, u_second_energy;
   logic [EW-1:0] u_fast_peak_energy, u_heavy_peak_energy;
   logic [dtc_pkg::POS_WIDTH-1:0] u_fast_peak_pos, u_heavy_peak_pos;

   logic [CW:0]   seen_before, seen_mid;
   logic [IW-1:0] fast_id, heavy_id;
   logic          out_free;
   dtc_pkg::dtc_result_type result;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = head_valid && (!head.last || out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign fast_id  = {1'b0, head.pos};
   assign heavy_id = {1'b0, head.pos} + ID_OFFSET;
   assign seen_before = {1'b0, fast_count_ff} + {1'b0, heavy_count_ff};
   assign seen_mid    = seen_before + {{CW{1'b0}}, head.fast_hit};

   always_comb begin
      u_vetoed            = vetoed_ff;
      u_armed             = armed_ff;
      u_fast_count        = fast_count_ff;
      u_heavy_count       = heavy_count_ff;
      u_first_id          = first_id_ff;
      u_first_energy      = first_energy_ff;
      u_second_id         = second_id_ff;
      u_second_energy     = second_energy_ff;
      u_fast_peak_energy  = fast_peak_energy_ff;
      u_fast_peak_pos     = fast_peak_pos_ff;
      u_heavy_peak_energy = heavy_peak_energy_ff;
      u_heavy_peak_pos    = heavy_peak_pos_ff;
      if (!head.skip) begin
         u_vetoed = vetoed_ff || head.veto;
         u_armed  = armed_ff || head.arm;
         // The first two hits are kept in scan order, fast before high-Z.
         if (head.fast_hit) begin
            if (seen_before == '0) begin
               u_first_id     = fast_id;
               u_first_energy = head.fast_energy;
            end else if (seen_before == (CW+1)'(1)) begin
               u_second_id     = fast_id;
               u_second_energy = head.fast_energy;
            end
            if (fast_count_ff != dtc_pkg::COUNT_MAX) begin
               u_fast_count = fast_count_ff + 1'b1;
            end
         end
         if (head.heavy_hit) begin
            if (seen_mid == '0) begin
               u_first_id     = heavy_id;
               u_first_energy = head.heavy_energy;
            end else if (seen_mid == (CW+1)'(1)) begin
               u_second_id     = heavy_id;
               u_second_energy = head.heavy_energy;
            end
            if (heavy_count_ff != dtc_pkg::COUNT_MAX) begin
               u_heavy_count = heavy_count_ff + 1'b1;
            end
         end
         if (head.fast_hit && (head.fast_energy > fast_peak_energy_ff)) begin
            u_fast_peak_energy = head.fast_energy;
            u_fast_peak_pos    = head.pos;
         end
         if (head.heavy_hit && (head.heavy_energy > heavy_peak_energy_ff)) begin
            u_heavy_peak_energy = head.heavy_energy;
            u_heavy_peak_pos    = head.pos;
         end
      end
   end

   always_comb begin
      result = '0;
      if (u_vetoed) begin
         result.status = dtc_pkg::STATUS_VETOED;
      end else if (!u_armed) begin
         result.status = dtc_pkg::STATUS_NO_TRIGGER;
      end else begin
         result.status     = dtc_pkg::STATUS_ACCEPTED;
         result.fast_hits  = u_fast_count;
         result.heavy_hits = u_heavy_count;
         if (({1'b0, u_fast_count} + {1'b0, u_heavy_count}) == (CW+1)'(2)) begin
            if (u_second_energy < u_first_energy) begin
               result.low_hit_id  = u_second_id;
               result.high_hit_id = u_first_id;
            end else begin
               result.low_hit_id  = u_first_id;
               result.high_hit_id = u_second_id;
            end
            // Ties between the two maxima go to the high-Z hit.
            if (u_fast_peak_energy > u_heavy_peak_energy) begin
               result.photo_id = {1'b0, u_fast_peak_pos};
            end else begin
               result.photo_id = {1'b0, u_heavy_peak_pos} + ID_OFFSET;
            end
            result.compton_id = (u_first_id == result.photo_id) ? u_second_id : u_first_id;
         end
      end
   end

   always_comb begin
      vetoed_in            = vetoed_ff;
      armed_in             = armed_ff;
      fast_count_in        = fast_count_ff;
      heavy_count_in       = heavy_count_ff;
      first_id_in          = first_id_ff;
      first_energy_in      = first_energy_ff;
      second_id_in         = second_id_ff;
      second_energy_in     = second_energy_ff;
      fast_peak_energy_in  = fast_peak_energy_ff;
      fast_peak_pos_in     = fast_peak_pos_ff;
      heavy_peak_energy_in = heavy_peak_energy_ff;
      heavy_peak_pos_in    = heavy_peak_pos_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_in               = rsp_ff;
      if (pop) begin
         if (head.last) begin
            vetoed_in            = 1'b0;
            armed_in             = 1'b0;
            fast_count_in        = '0;
            heavy_count_in       = '0;
            first_id_in          = '0;
            first_energy_in      = '0;
            second_id_in         = '0;
            second_energy_in     = '0;
            fast_peak_energy_in  = '0;
            fast_peak_pos_in     = '0;
            heavy_peak_energy_in = '0;
            heavy_peak_pos_in    = '0;
            rsp_valid_in         = 1'b1;
            rsp_in               = result;
         end else begin
            vetoed_in            = u_vetoed;
            armed_in             = u_armed;
            fast_count_in        = u_fast_count;
            heavy_count_in       = u_heavy_count;
            first_id_in          = u_first_id;
            first_energy_in      = u_first_energy;
            second_id_in         = u_second_id;
            second_energy_in     = u_second_energy;
            fast_peak_energy_in  = u_fast_peak_energy;
            fast_peak_pos_in     = u_fast_peak_pos;
            heavy_peak_energy_in = u_heavy_peak_energy;
            heavy_peak_pos_in    = u_heavy_peak_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vetoed_ff            <= 1'b0;
         armed_ff             <= 1'b0;
         fast_count_ff        <= '0;
         heavy_count_ff       <= '0;
         first_id_ff          <= '0;
         first_energy_ff      <= '0;
         second_id_ff         <= '0;
         second_energy_ff     <= '0;
         fast_peak_energy_ff  <= '0;
         fast_peak_pos_ff     <= '0;
         heavy_peak_energy_ff <= '0;
         heavy_peak_pos_ff    <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         vetoed_ff            <= vetoed_in;
         armed_ff             <= armed_in;
         fast_count_ff        <= fast_count_in;
         heavy_count_ff       <= heavy_count_in;
         first_id_ff          <= first_id_in;
         first_energy_ff      <= first_energy_in;
         second_id_ff         <= second_id_in;
         second_energy_ff     <= second_energy_in;
         fast_peak_energy_ff  <= fast_peak_energy_in;
         fast_peak_pos_ff     <= fast_peak_pos_in;
         heavy_peak_energy_ff <= heavy_peak_energy_in;
         heavy_peak_pos_ff    <= heavy_peak_pos_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/detector_event_trigger_classifier.sv]
// ----------------------------------------------------------------------------
// Detector event trigger classifier
// Classifies a stream of channel words into per-event trigger results.
// ----------------------------------------------------------------------------
// One channel word is taken per clock, back to back, while the queue has room
// (req_stall is high when it is full). The front end classifies each word in
// the cycle it is accepted and writes it into a four-word queue; the back end
// folds one word per clock into the event state, so the rate is set by that
// single update step, but a last word waits while a result is held. An event's
// last word passes the queue memory and then the output register; the next
// event's words keep flowing while a result waits on rsp_stall.
module detector_event_trigger_classifier #(
   parameter int POSITIONS       = 60,
   parameter int HEAVY_ID_OFFSET = 28,
   parameter int ENERGY_BITS     = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_write_enable,
   input  logic [dtc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dtc_pkg::ENERGY_WIDTH-1:0]       csr_data,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [dtc_pkg::ENERGY_WIDTH-1:0]       req_fast_energy,
   input  logic [dtc_pkg::ENERGY_WIDTH-1:0]       req_heavy_energy,
   input  logic                                   req_last_channel,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [dtc_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic [dtc_pkg::COUNT_WIDTH-1:0]        rsp_fast_hits,
   output logic [dtc_pkg::COUNT_WIDTH-1:0]        rsp_heavy_hits,
   output logic [dtc_pkg::ID_WIDTH-1:0]           rsp_low_hit_id,
   output logic [dtc_pkg::ID_WIDTH-1:0]           rsp_high_hit_id,
   output logic [dtc_pkg::ID_WIDTH-1:0]           rsp_photo_id,
   output logic [dtc_pkg::ID_WIDTH-1:0]           rsp_compton_id
);

   dtc_pkg::dtc_cfg_type          cfg_ff, cfg_in;
   dtc_pkg::dtc_entry_type        push_entry, head;
   dtc_pkg::dtc_queue_status_type queue_status;
   dtc_pkg::dtc_result_type       rsp;
   logic                          push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dtc_pkg::REG_FAST_HIT_THRESHOLD:      cfg_in.fast_hit_threshold      = csr_data;
            dtc_pkg::REG_FAST_TRIGGER_THRESHOLD:  cfg_in.fast_trigger_threshold  = csr_data;
            dtc_pkg::REG_HEAVY_HIT_THRESHOLD:     cfg_in.heavy_hit_threshold     = csr_data;
            dtc_pkg::REG_HEAVY_TRIGGER_THRESHOLD: cfg_in.heavy_trigger_threshold = csr_data;
            dtc_pkg::REG_UPPER_LIMIT:             cfg_in.upper_limit             = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_hit_threshold      <= 16'd2;
         cfg_ff.fast_trigger_threshold  <= 16'd30;
         cfg_ff.heavy_hit_threshold     <= 16'd50;
         cfg_ff.heavy_trigger_threshold <= 16'd50;
         cfg_ff.upper_limit             <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtc_front #(
      .POSITIONS   (POSITIONS),
      .ENERGY_BITS (ENERGY_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_fast_energy  (req_fast_energy),
      .req_heavy_energy (req_heavy_energy),
      .req_last_channel (req_last_channel),
      .queue_full       (queue_status.full),
      .push             (push),
      .entry            (push_entry)
   );

   dtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   dtc_back #(
      .HEAVY_ID_OFFSET (HEAVY_ID_OFFSET)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!queue_status.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_status      = rsp.status;
   assign rsp_fast_hits   = rsp.fast_hits;
   assign rsp_heavy_hits  = rsp.heavy_hits;
   assign rsp_low_hit_id  = rsp.low_hit_id;
   assign rsp_high_hit_id = rsp.high_hit_id;
   assign rsp_photo_id    = rsp.photo_id;
   assign rsp_compton_id  = rsp.compton_id;

   // A word is only accepted when the queue has room for it.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !queue_status.full)
      else $error("word accepted into a full queue");

   // The queue level never exceeds its depth.
   assert property (@(posedge clock) disable iff (reset)
      queue_status.level <= dtc_pkg::QUEUE_LEVEL_WIDTH'(dtc_pkg::QUEUE_DEPTH))
      else $error("queue level beyond depth");

   // Rejected events carry no counts and no ids.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != dtc_pkg::STATUS_ACCEPTED)) |->
         (rsp_fast_hits == '0) && (rsp_heavy_hits == '0) && (rsp_low_hit_id == '0) &&
         (rsp_high_hit_id == '0) && (rsp_photo_id == '0) && (rsp_compton_id == '0))
      else $error("rejected event result carries hit data");

   // The back end pops only a word that is present.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("pop from an empty queue");

endmodule
